// ===== rtl/core/bbr_pkg.sv =====
package bbr_pkg;

  localparam int unsigned DefMaxWidth = 1024;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned RowW        = 12;
  localparam int unsigned CfgWidthW   = 11;
  localparam int unsigned CfgHeightW  = 13;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned WidthReset  = 1024;
  localparam int unsigned HeightReset = 1024;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned PixW        = 3 * ChanW;
  localparam int unsigned CsumW       = 10;
  localparam int unsigned SumW        = 12;
  localparam int unsigned JobDepth    = 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    Div4 = 2'd0,
    Div6 = 2'd1,
    Div9 = 2'd2
  } div_e;

  // One mean to compute: per-column channel sums, the columns that count,
  // and the divisor that goes with them.
  typedef struct packed {
    logic [2:0][2:0][CsumW-1:0] csum;
    logic [2:0]                 col_mask;
    div_e                       div;
    logic                       eof;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } fifo_wr_t;

endpackage

// ===== rtl/core/box_blur_3x3_rgb_core.sv =====
// Channel   Direction  Handshake              Payload
// input     in         push / full            func_i, in_c0_i, in_c1_i, in_c2_i
// result    out        empty / pop            out_c0_o, out_c1_o, out_c2_o,
//                                             end_of_frame_o, last_in_run_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item is taken per cycle while full is low, and results leave at one per
// cycle while pop is held; results pass the front registers, queue and back end.
// The line store has one read port per bank, so full rises for one cycle
// after the last pixel of a frame while column zero is fetched for the drain.
// Reset clears control state only; the line store needs no clearing pass.
// The job queue holds eight means, and full rises when fewer than four slots
// are free, so a stalled result port backs up into the input.
module box_blur_3x3_rgb_core import bbr_pkg::*; #(
  parameter int unsigned MaxWidth = DefMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                func_i,
  input  logic [ChanW-1:0]    in_c0_i,
  input  logic [ChanW-1:0]    in_c1_i,
  input  logic [ChanW-1:0]    in_c2_i,
  output logic                empty,
  input  logic                pop,
  output logic [ChanW-1:0]    out_c0_o,
  output logic [ChanW-1:0]    out_c1_o,
  output logic [ChanW-1:0]    out_c2_o,
  output logic                end_of_frame_o,
  output logic                last_in_run_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  fifo_wr_t wr;
  job_t     job0;
  job_t     job1;
  job_t     head;
  logic     job_empty;
  logic     job_pop;
  logic     space;

  assign cfg_ready_o = 1'b1;

  bbr_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .in_c0_i      (in_c0_i),
    .in_c1_i      (in_c1_i),
    .in_c2_i      (in_c2_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fifo_space_i (space),
    .wr_o         (wr),
    .job0_o       (job0),
    .job1_o       (job1)
  );

  bbr_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .job0_i  (job0),
    .job1_i  (job1),
    .pop_i   (job_pop),
    .head_o  (head),
    .empty_o (job_empty),
    .space_o (space)
  );

  bbr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (head),
    .job_empty_i    (job_empty),
    .job_pop_o      (job_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_c0_o       (out_c0_o),
    .out_c1_o       (out_c1_o),
    .out_c2_o       (out_c2_o),
    .end_of_frame_o (end_of_frame_o),
    .last_in_run_o  (last_in_run_o)
  );

endmodule

// ===== rtl/core/bbr_front.sv =====
module bbr_front import bbr_pkg::*; #(
  parameter int unsigned MaxWidth = DefMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                func_i,
  input  logic [ChanW-1:0]    in_c0_i,
  input  logic [ChanW-1:0]    in_c1_i,
  input  logic [ChanW-1:0]    in_c2_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                fifo_space_i,
  output fifo_wr_t            wr_o,
  output job_t                job0_o,
  output job_t                job1_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);

  typedef enum logic [0:0] {
    FuncPixel = 1'b0,
    FuncFlush = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    OpNone,
    OpPixel,
    OpDrain,
    OpPrime
  } op_e;

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [RowW-1:0]       row_q;
  logic [ColW-1:0]       col_q;
  logic [ColW-1:0]       drain_q;
  logic                  draining_q;
  logic                  prime_q;
  op_e                   op_q;

  logic [ColW-1:0] last_col;
  logic [RowW-1:0] last_row;
  logic            drain_sel;
  logic            blocked;
  logic            accept;
  logic            take_pix;
  logic            take_flush;
  logic [ColW-1:0] rd_addr;
  logic [PixW-1:0] pix;

  logic [PixW-1:0] bank0_mem [MaxWidth];
  logic [PixW-1:0] bank1_mem [MaxWidth];
  logic [PixW-1:0] rd0_q;
  logic [PixW-1:0] rd1_q;

  logic            sel_d, rv0_d, cv0_d, cv2_d, emit_a_d, emit_b_d, eof_d;
  logic            sel_q, rv0_q, rv2_q, cv0_q, cv2_q, emit_a_q, emit_b_q, eof_q;
  logic [PixW-1:0] pix_q;

  logic [2:0][2:0][PixW-1:0]  win_q;
  logic [2:0][2:0][PixW-1:0]  nwin;
  logic [2:0][2:0][CsumW-1:0] colsum;

  function automatic div_e div_for(input logic rows3, input logic cols3);
    if (rows3) begin
      div_for = cols3 ? Div9 : Div6;
    end else begin
      div_for = cols3 ? Div6 : Div4;
    end
  endfunction

  // Out-of-range sizes act as the nearest legal size.
  always_comb begin
    if (width_q < CfgWidthW'(2)) begin
      last_col = ColW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      last_col = ColW'(MaxWidth - 1);
    end else begin
      last_col = ColW'(width_q - CfgWidthW'(1));
    end
    if (height_q < CfgHeightW'(2)) begin
      last_row = RowW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      last_row = RowW'(MaxHeight - 1);
    end else begin
      last_row = RowW'(height_q - CfgHeightW'(1));
    end
  end

  // While draining, the row above the last one sits in the bank of the
  // frame height's parity.
  assign drain_sel  = ~last_row[0];
  assign blocked    = draining_q && prime_q;
  assign full_o     = !fifo_space_i || blocked;
  assign accept     = push_i && !full_o;
  assign take_pix   = accept && (func_e'(func_i) == FuncPixel) && !draining_q;
  assign take_flush = accept && (func_e'(func_i) == FuncFlush) && draining_q;
  assign pix        = {in_c2_i, in_c1_i, in_c0_i};

  // The drain runs one column ahead; the prime read fetches column zero.
  always_comb begin
    if (blocked) begin
      rd_addr = '0;
    end else if (draining_q) begin
      rd_addr = ColW'(drain_q + ColW'(1));
    end else begin
      rd_addr = col_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pix && !row_q[0]) begin
      bank0_mem[col_q] <= pix;
    end
    rd0_q <= bank0_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take_pix && row_q[0]) begin
      bank1_mem[col_q] <= pix;
    end
    rd1_q <= bank1_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= CfgWidthW'(WidthReset);
      height_q   <= CfgHeightW'(HeightReset);
      row_q      <= '0;
      col_q      <= '0;
      drain_q    <= '0;
      draining_q <= 1'b0;
      prime_q    <= 1'b0;
      op_q       <= OpNone;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegFrameWidth: begin
          width_q <= cfg_data_i[CfgWidthW-1:0];
        end
        RegFrameHeight: begin
          height_q <= cfg_data_i[CfgHeightW-1:0];
        end
        default: begin
        end
      endcase
      row_q      <= '0;
      col_q      <= '0;
      drain_q    <= '0;
      draining_q <= 1'b0;
      prime_q    <= 1'b0;
      op_q       <= OpNone;
    end else begin
      if (blocked) begin
        op_q    <= OpPrime;
        prime_q <= 1'b0;
      end else if (take_pix) begin
        op_q <= OpPixel;
      end else if (take_flush) begin
        op_q <= OpDrain;
      end else begin
        op_q <= OpNone;
      end
      if (take_pix) begin
        if (col_q == last_col) begin
          col_q <= '0;
          if (row_q == last_row) begin
            row_q      <= '0;
            draining_q <= 1'b1;
            drain_q    <= '0;
            prime_q    <= 1'b1;
          end else begin
            row_q <= row_q + RowW'(1);
          end
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
      if (take_flush) begin
        if (drain_q == last_col) begin
          drain_q    <= '0;
          draining_q <= 1'b0;
        end else begin
          drain_q <= drain_q + ColW'(1);
        end
      end
    end
  end

  always_comb begin
    if (draining_q) begin
      sel_d    = drain_sel;
      rv0_d    = 1'b1;
      cv0_d    = drain_q != '0;
      cv2_d    = drain_q != last_col;
      emit_a_d = 1'b1;
      emit_b_d = 1'b0;
      eof_d    = drain_q == last_col;
    end else begin
      sel_d    = row_q[0];
      rv0_d    = row_q >= RowW'(2);
      cv0_d    = 32'(col_q) >= 2;
      cv2_d    = 1'b1;
      emit_a_d = (row_q != '0) && (col_q != '0);
      emit_b_d = (row_q != '0) && (col_q == last_col);
      eof_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    rv0_q    <= rv0_d;
    rv2_q    <= !draining_q;
    cv0_q    <= cv0_d;
    cv2_q    <= cv2_d;
    emit_a_q <= emit_a_d;
    emit_b_q <= emit_b_d;
    eof_q    <= eof_d;
    pix_q    <= pix;
  end

  // Window rows: two rows up, one row up, current row. Column two is newest.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nwin[i][0] = win_q[i][1];
      nwin[i][1] = win_q[i][2];
    end
    nwin[0][2] = sel_q ? rd1_q : rd0_q;
    nwin[1][2] = sel_q ? rd0_q : rd1_q;
    nwin[2][2] = pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (op_q != OpNone) begin
      win_q <= nwin;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int ch = 0; ch < 3; ch++) begin
        colsum[j][ch] = CsumW'(rv0_q ? nwin[0][j][ch*ChanW +: ChanW] : '0)
                      + CsumW'(nwin[1][j][ch*ChanW +: ChanW])
                      + CsumW'(rv2_q ? nwin[2][j][ch*ChanW +: ChanW] : '0);
      end
    end
  end

  always_comb begin
    job0_o.csum     = colsum;
    job0_o.col_mask = {cv2_q, 1'b1, cv0_q};
    job0_o.div      = div_for(rv0_q && rv2_q, cv0_q && cv2_q);
    job0_o.eof      = eof_q;
    job0_o.last     = !emit_b_q;

    // The right-edge mean of a row: the two newest columns only.
    job1_o.csum[0]  = colsum[1];
    job1_o.csum[1]  = colsum[2];
    job1_o.csum[2]  = colsum[2];
    job1_o.col_mask = 3'b011;
    job1_o.div      = div_for(rv0_q && rv2_q, 1'b0);
    job1_o.eof      = 1'b0;
    job1_o.last     = 1'b1;

    wr_o.push0 = ((op_q == OpPixel) || (op_q == OpDrain)) && emit_a_q;
    wr_o.push1 = (op_q == OpPixel) && emit_b_q;
  end

endmodule

// ===== rtl/core/bbr_job_fifo.sv =====
module bbr_job_fifo import bbr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fifo_wr_t wr_i,
  input  job_t     job0_i,
  input  job_t     job1_i,
  input  logic     pop_i,
  output job_t     head_o,
  output logic     empty_o,
  output logic     space_o
);

  localparam int unsigned PtrW = $clog2(JobDepth);
  localparam int unsigned CntW = $clog2(JobDepth + 1);

  job_t            q_mem [JobDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign empty_o = cnt_q == '0;
  assign head_o  = q_mem[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;
  // Room for two items in flight, two results each.
  assign space_o = cnt_q <= CntW'(JobDepth - 4);

  always_ff @(posedge clk_i) begin
    if (wr_i.push0) begin
      q_mem[wr_ptr_q] <= job0_i;
    end
    if (wr_i.push1) begin
      q_mem[PtrW'(wr_ptr_q + PtrW'(1))] <= job1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(wr_i.push0) + PtrW'(wr_i.push1);
      rd_ptr_q <= rd_ptr_q + PtrW'(do_pop);
      cnt_q    <= cnt_q + CntW'(wr_i.push0) + CntW'(wr_i.push1) - CntW'(do_pop);
    end
  end

endmodule

// ===== rtl/core/bbr_back.sv =====
module bbr_back import bbr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  job_t             job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [ChanW-1:0] out_c0_o,
  output logic [ChanW-1:0] out_c1_o,
  output logic [ChanW-1:0] out_c2_o,
  output logic             end_of_frame_o,
  output logic             last_in_run_o
);

  localparam int unsigned RecipW = 15;
  localparam int unsigned ProdW  = SumW + RecipW;

  logic                       a_v_q;
  logic [2:0][SumW-1:0]       a_sum_q;
  div_e                       a_div_q;
  logic                       a_eof_q;
  logic                       a_last_q;
  logic                       o_v_q;
  logic [2:0][ChanW-1:0]      o_mean_q;
  logic                       o_eof_q;
  logic                       o_last_q;

  logic                       o_ready;
  logic                       a_ready;
  logic [2:0][SumW-1:0]       sum;
  logic [2:0][ChanW-1:0]      mean;
  logic [RecipW-1:0]          recip;
  logic [ProdW-1:0]           prod [3];

  // Reciprocals scaled by 2^16; exact truncation for sums up to 9 * 255.
  always_comb begin
    case (a_div_q)
      Div4:    recip = RecipW'(16384);
      Div6:    recip = RecipW'(10923);
      Div9:    recip = RecipW'(7282);
      default: recip = RecipW'(16384);
    endcase
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = SumW'(job_i.col_mask[0] ? job_i.csum[0][ch] : '0)
              + SumW'(job_i.col_mask[1] ? job_i.csum[1][ch] : '0)
              + SumW'(job_i.col_mask[2] ? job_i.csum[2][ch] : '0);
      prod[ch] = ProdW'(a_sum_q[ch]) * ProdW'(recip);
      mean[ch] = prod[ch][16 +: ChanW];
    end
  end

  assign o_ready   = !o_v_q || pop_i;
  assign a_ready   = !a_v_q || o_ready;
  assign job_pop_o = a_ready && !job_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_q <= !job_empty_i;
      end
      if (o_ready) begin
        o_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      a_sum_q  <= sum;
      a_div_q  <= job_i.div;
      a_eof_q  <= job_i.eof;
      a_last_q <= job_i.last;
    end
    if (o_ready && a_v_q) begin
      o_mean_q <= mean;
      o_eof_q  <= a_eof_q;
      o_last_q <= a_last_q;
    end
  end

  assign empty_o        = !o_v_q;
  assign out_c0_o       = o_mean_q[0];
  assign out_c1_o       = o_mean_q[1];
  assign out_c2_o       = o_mean_q[2];
  assign end_of_frame_o = o_eof_q;
  assign last_in_run_o  = o_last_q;

endmodule

// ===== tb/box_blur_3x3_rgb_core_tb.sv =====
module box_blur_3x3_rgb_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbr_pkg::*;

  localparam int unsigned IdleMax      = 14;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned RandomItems  = 1000;

  typedef enum logic {
    KindPixel = 1'b0,
    KindFlush = 1'b1
  } item_kind_e;

  typedef enum int {
    FillRandom,
    FillZero,
    FillMax
  } fill_e;

  typedef bit [PixW-1:0] grid_t [3][3];

  typedef struct packed {
    bit [ChanW-1:0] c0;
    bit [ChanW-1:0] c1;
    bit [ChanW-1:0] c2;
    bit             eof;
    bit             last;
  } blur_mean_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic                func_i;
  logic [ChanW-1:0]    in_c0_i;
  logic [ChanW-1:0]    in_c1_i;
  logic [ChanW-1:0]    in_c2_i;
  logic                empty;
  logic                pop;
  logic [ChanW-1:0]    out_c0_o;
  logic [ChanW-1:0]    out_c1_o;
  logic [ChanW-1:0]    out_c2_o;
  logic                end_of_frame_o;
  logic                last_in_run_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predicted block state.
  bit [PixW-1:0]       line_mem [2*DefMaxWidth];
  grid_t               win;
  int unsigned         row_pos;
  int unsigned         col_pos;
  int unsigned         drain_pos;
  bit                  draining;
  bit [CfgWidthW-1:0]  width_reg;
  bit [CfgHeightW-1:0] height_reg;

  blur_mean_t  mean_q[$];
  int unsigned mismatch_count;
  int unsigned useful_items;
  bit          in_idle_on;
  bit          out_idle_on;
  bit          hold_req;

  box_blur_3x3_rgb_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .in_c0_i       (in_c0_i),
    .in_c1_i       (in_c1_i),
    .in_c2_i       (in_c2_i),
    .empty         (empty),
    .pop           (pop),
    .out_c0_o      (out_c0_o),
    .out_c1_o      (out_c1_o),
    .out_c2_o      (out_c2_o),
    .end_of_frame_o(end_of_frame_o),
    .last_in_run_o (last_in_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > DefMaxWidth) return DefMaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 2) return 2;
    if (height_reg > MaxHeight) return MaxHeight;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    win       = '{default: '0};
    row_pos   = 0;
    col_pos   = 0;
    drain_pos = 0;
    draining  = 1'b0;
  endfunction

  // Mean over the cells whose row and column both lie inside the frame.
  function automatic blur_mean_t mean_of(grid_t g, bit [2:0] rv, bit [2:0] cv, bit eof);
    blur_mean_t  res;
    int unsigned s0, s1, s2, n;
    s0 = 0;
    s1 = 0;
    s2 = 0;
    n  = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rv[i] && cv[j]) begin
          s0 += g[i][j][ChanW-1:0];
          s1 += g[i][j][2*ChanW-1:ChanW];
          s2 += g[i][j][PixW-1:2*ChanW];
          n++;
        end
      end
    end
    if (n == 0) n = 1;
    res.c0   = ChanW'(s0 / n);
    res.c1   = ChanW'(s1 / n);
    res.c2   = ChanW'(s2 / n);
    res.eof  = eof;
    res.last = 1'b0;
    return res;
  endfunction

  // Advances the predicted state by one item and queues the means it yields.
  // Returns 0 when the block drops the item.
  function automatic bit predict_item(item_kind_e kind, bit [ChanW-1:0] c0,
                                      bit [ChanW-1:0] c1, bit [ChanW-1:0] c2);
    blur_mean_t    res [2];
    grid_t         g;
    bit [2:0]      rv;
    bit [2:0]      cv;
    bit [PixW-1:0] pix;
    int unsigned   w, h, r, c, d, n, i;
    int unsigned   prev_base, last_base, same_base, other_base;
    bit            used;
    w    = eff_width();
    h    = eff_height();
    n    = 0;
    used = 1'b0;
    if (kind == KindFlush) begin
      if (draining) begin
        used = 1'b1;
        d = (drain_pos >= w) ? w - 1 : drain_pos;
        // The final row lives in the bank of row h-1, the row above it in the other one.
        last_base = ((h - 1) & 1) * DefMaxWidth;
        prev_base = (((h - 1) & 1) ^ 1) * DefMaxWidth;
        cv = {d + 1 < w, 1'b1, d >= 1};
        rv = 3'b011;
        g  = '{default: '0};
        g[0][1] = line_mem[prev_base + d];
        g[1][1] = line_mem[last_base + d];
        if (cv[0]) begin
          g[0][0] = line_mem[prev_base + d - 1];
          g[1][0] = line_mem[last_base + d - 1];
        end
        if (cv[2]) begin
          g[0][2] = line_mem[prev_base + d + 1];
          g[1][2] = line_mem[last_base + d + 1];
        end
        res[0] = mean_of(g, rv, cv, d == w - 1);
        n = 1;
        d++;
        if (d >= w) begin
          draining = 1'b0;
          d = 0;
        end
        drain_pos = d;
      end
    end else if (!draining) begin
      used = 1'b1;
      r = (row_pos >= h) ? h - 1 : row_pos;
      c = (col_pos >= w) ? w - 1 : col_pos;
      pix = {c2, c1, c0};
      same_base  = (r & 1) * DefMaxWidth;
      other_base = ((r & 1) ^ 1) * DefMaxWidth;
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = line_mem[same_base + c];
      win[1][2] = line_mem[other_base + c];
      win[2][2] = pix;
      line_mem[same_base + c] = pix;
      if (r >= 1) begin
        rv = {1'b1, 1'b1, r >= 2};
        if (c >= 1) begin
          res[n] = mean_of(win, rv, {1'b1, 1'b1, c >= 2}, 1'b0);
          n++;
        end
        // The last column also closes the mean of the pixel right above it.
        if (c == w - 1) begin
          for (i = 0; i < 3; i++) begin
            g[i][0] = win[i][1];
            g[i][1] = win[i][2];
            g[i][2] = '0;
          end
          res[n] = mean_of(g, rv, 3'b011, 1'b0);
          n++;
        end
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r         = 0;
          draining  = 1'b1;
          drain_pos = 0;
        end
      end
      row_pos = r;
      col_pos = c;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) mean_q.push_back(res[i]);
    return used;
  endfunction

  function automatic bit [ChanW-1:0] chan_value(fill_e fill);
    if (fill == FillZero) return '0;
    if (fill == FillMax) return '1;
    case ($urandom_range(15, 0))
      0: return '0;
      1: return '1;
      default: return ChanW'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_item(item_kind_e kind, bit [ChanW-1:0] c0, bit [ChanW-1:0] c1,
                           bit [ChanW-1:0] c2);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(IdleMax, 0) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    func_i  <= kind;
    in_c0_i <= c0;
    in_c1_i <= c1;
    in_c2_i <= c2;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (predict_item(kind, c0, c1, c2)) useful_items++;
  endtask

  // A flush slipped in before a pixel is dropped by the block.
  task automatic send_pixels(int unsigned count, fill_e fill, int unsigned noise_pct);
    repeat (count) begin
      if ($urandom_range(99, 0) < noise_pct) begin
        send_item(KindFlush, chan_value(FillRandom), chan_value(FillRandom),
                  chan_value(FillRandom));
      end
      send_item(KindPixel, chan_value(fill), chan_value(fill), chan_value(fill));
    end
  endtask

  // A pixel slipped in while the last row drains is dropped by the block.
  task automatic send_flushes(int unsigned count, int unsigned noise_pct);
    repeat (count) begin
      if ($urandom_range(99, 0) < noise_pct) begin
        send_item(KindPixel, chan_value(FillRandom), chan_value(FillRandom),
                  chan_value(FillRandom));
      end
      send_item(KindFlush, chan_value(FillRandom), chan_value(FillRandom),
                chan_value(FillRandom));
    end
  endtask

  task automatic send_frame(fill_e fill, int unsigned noise_pct);
    send_pixels(eff_width() * eff_height(), fill, noise_pct);
    send_flushes(eff_width(), noise_pct);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegFrameWidth) width_reg = val[CfgWidthW-1:0];
    else height_reg = val;
    restart_frame();
    @(posedge clk_i);
  endtask

  task automatic set_geometry(bit [CfgDataW-1:0] w_val, bit [CfgDataW-1:0] h_val);
    wait_idle();
    write_reg(RegFrameWidth, w_val);
    write_reg(RegFrameHeight, h_val);
  endtask

  // Reset geometry is 1024 x 1024: fill the first row and a few pixels of the
  // second, then leave the frame unfinished for the next write to restart.
  task automatic test_reset_geometry();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    send_item(KindFlush, '1, '1, '1);
    send_pixels(eff_width() + 4, FillRandom, 0);
  endtask

  task automatic test_small_frames();
    set_geometry(2, 2);
    send_frame(FillMax, 0);
    send_frame(FillZero, 0);
    set_geometry(3, 3);
    send_pixels(9, FillRandom, 0);
    send_item(KindPixel, '1, '0, '1);
    send_flushes(3, 0);
    send_item(KindFlush, '0, '1, '0);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    set_geometry(16, 6);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    hold_req    = 1'b1;
    send_frame(FillRandom, 0);
    in_idle_on  = 1'b1;
  endtask

  task automatic test_geometry_clamps();
    set_geometry(DefMaxWidth, 1);
    send_frame(FillRandom, 1);
    set_geometry(13'h1fff, 0);
    send_frame(FillRandom, 1);
    set_geometry(1, 13'h1fff);
    send_frame(FillRandom, 1);
    set_geometry(0, MaxHeight);
    send_frame(FillRandom, 1);
  endtask

  function automatic bit [CfgDataW-1:0] pick_width();
    case ($urandom_range(19, 0))
      0: return 0;
      1: return 1;
      2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15: return $urandom_range(8, 2);
      default: return $urandom_range(40, 9);
    endcase
  endfunction

  function automatic bit [CfgDataW-1:0] pick_height();
    case ($urandom_range(19, 0))
      0: return 0;
      1: return 1;
      2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15: return $urandom_range(6, 2);
      default: return $urandom_range(16, 7);
    endcase
  endfunction

  task automatic test_random_frames();
    bit          need_cfg;
    int unsigned choice;
    need_cfg     = 1'b1;
    useful_items = 0;
    while (useful_items < RandomItems) begin
      choice = $urandom_range(3, 0);
      if (need_cfg && choice == 3) choice = 2;
      if (choice != 3) begin
        wait_idle();
        if (choice != 1) write_reg(RegFrameWidth, pick_width());
        if (choice != 0) write_reg(RegFrameHeight, pick_height());
      end
      need_cfg    = 1'b0;
      in_idle_on  = ($urandom_range(9, 0) < 7);
      out_idle_on = ($urandom_range(9, 0) < 7);
      repeat ($urandom_range(3, 1)) send_frame(FillRandom, 5);
      // Now and then a frame is cut short and only a register write restarts it.
      if ($urandom_range(9, 0) == 0) begin
        send_pixels($urandom_range(eff_width() * eff_height() - 1, 1), FillRandom, 5);
        need_cfg = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    push           <= 1'b0;
    func_i         <= KindPixel;
    in_c0_i        <= '0;
    in_c1_i        <= '0;
    in_c2_i        <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= RegFrameWidth;
    cfg_data_i     <= '0;
    rst_ni         <= 1'b0;
    hold_req       = 1'b0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    mismatch_count = 0;
    useful_items   = 0;
    width_reg      = WidthReset;
    height_reg     = HeightReset;
    restart_frame();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_small_frames();
    test_backpressure();
    test_geometry_clamps();
    test_random_frames();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("[box_blur_3x3_rgb_core] OK");
    end else begin
      $display("[box_blur_3x3_rgb_core] ERROR");
    end
    $finish;
  end

  initial begin : result_check
    int unsigned stall;
    blur_mean_t  got;
    blur_mean_t  want;
    stall = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = {out_c0_o, out_c1_o, out_c2_o, end_of_frame_o, last_in_run_o};
        if (mean_q.size() == 0) begin
          $display("%0t: expected no item, got c0=%0d c1=%0d c2=%0d eof=%0b last=%0b",
                   $time, got.c0, got.c1, got.c2, got.eof, got.last);
          mismatch_count++;
        end else begin
          want = mean_q.pop_front();
          check_field("out_c0", want.c0, got.c0);
          check_field("out_c1", want.c1, got.c1);
          check_field("out_c2", want.c2, got.c2);
          check_field("end_of_frame", want.eof, got.eof);
          check_field("last_in_run", want.last, got.last);
        end
        stall = out_idle_on ? $urandom_range(IdleMax, 0) : 0;
      end
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("[box_blur_3x3_rgb_core] ERROR");
        $finish;
      end
    end
  end

endmodule
